FILE: design/dfht_pkg.sv
// Package for the dominance filtered hit table.
// Holds the opcode codes, the controller command and status structs.
`timescale 1ns / 1ps

package dfht_pkg;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_JUDGE = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic judge;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: design/dfht_datapath.sv
// Datapath of the dominance filtered hit table: slot memory, neighbor scan,
// dominance test, slot write and primary hit registers. Uses dfht_pkg.
`timescale 1ns / 1ps

module dfht_datapath import dfht_pkg::*; #(
  parameter int TableDepth   = 64,
  parameter int PositionBits = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic                    opcode_i,
  input  logic [9:0]              ref_index_i,
  input  logic [31:0]             span_offset_i,
  input  logic [31:0]             span_length_i,
  input  logic [31:0]             reversed_end_i,
  input  logic [7:0]              candidate_errors_i,
  input  logic [15:0]             aligned_length_i,
  input  logic [7:0]              aligned_errors_i,
  input  logic signed [15:0]      aligned_score_i,
  input  logic                    reverse_strand_i,
  output logic                    inserted_o,
  output logic                    table_full_o,
  output logic                    best_valid_o,
  output logic signed [15:0]      best_score_o,
  output logic [31:0]             best_end_o,
  output logic [9:0]              best_reference_o
);

  localparam int IdxBits = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntBits = $clog2(TableDepth + 1);
  localparam int PB      = PositionBits;

  logic [TableDepth-1:0] used_q;

  logic [9:0]    mem_ref   [TableDepth];
  logic [PB-1:0] mem_start [TableDepth];
  logic [7:0]    mem_err   [TableDepth];
  logic [PB-1:0] mem_end   [TableDepth];
  logic [15:0]   mem_score [TableDepth];
  logic          mem_strand[TableDepth];

  logic [9:0]    ref_q;
  logic [PB-1:0] start_q;
  logic [7:0]    cerr_q;
  logic [15:0]   alen_q;
  logic [7:0]    aerr_q;
  logic [15:0]   ascore_q;
  logic          strand_q;
  logic          op_q;

  logic [CntBits-1:0] rd_cnt_q;
  logic [IdxBits-1:0] rd_idx_q;
  logic               rd_vld_q;
  logic               rd_used_q;
  logic [9:0]         rd_ref_q;
  logic [PB-1:0]      rd_start_q;
  logic [7:0]         rd_err_q;

  logic               r_found_q, l_found_q, f_found_q;
  logic [IdxBits-1:0] r_idx_q, l_idx_q, f_idx_q;
  logic [PB-1:0]      r_start_q, l_start_q;
  logic [7:0]         r_err_q, l_err_q;

  logic               rej_q, full_q, r_erase_q, l_erase_q;
  logic [IdxBits-1:0] tgt_q;
  logic [PB-1:0]      end_q;

  logic               pres_q;
  logic signed [15:0] pscore_q;
  logic [PB-1:0]      pend_q;
  logic [9:0]         pref_q;

  logic               ins_q, full_out_q;

  logic [PB-1:0] start_calc;
  assign start_calc = PB'(span_length_i) - PB'(reversed_end_i) + PB'(span_offset_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      ref_q    <= ref_index_i;
      start_q  <= start_calc;
      cerr_q   <= candidate_errors_i;
      alen_q   <= aligned_length_i;
      aerr_q   <= aligned_errors_i;
      ascore_q <= aligned_score_i;
      strand_q <= reverse_strand_i;
    end
    rd_idx_q   <= rd_cnt_q[IdxBits-1:0];
    rd_ref_q   <= mem_ref[rd_cnt_q[IdxBits-1:0]];
    rd_start_q <= mem_start[rd_cnt_q[IdxBits-1:0]];
    rd_err_q   <= mem_err[rd_cnt_q[IdxBits-1:0]];
    rd_used_q  <= used_q[rd_cnt_q[IdxBits-1:0]];
    if (cmd_i.commit && !rej_q && !full_q) begin
      mem_ref[tgt_q]    <= ref_q;
      mem_start[tgt_q]  <= start_q;
      mem_err[tgt_q]    <= aerr_q;
      mem_end[tgt_q]    <= end_q;
      mem_score[tgt_q]  <= ascore_q;
      mem_strand[tgt_q] <= strand_q;
    end
  end

  function automatic logic dominates(input logic [PB-1:0] s, input logic [PB-1:0] c,
                                     input logic [7:0] e, input logic [7:0] ce,
                                     output logic worse);
    logic [PB-1:0] gap;
    logic [7:0]    diff;
    gap   = (s >= c) ? s - c : c - s;
    diff  = (e > ce) ? e - ce : ce - e;
    worse = (e > ce) && (gap <= PB'(diff));
    return (e <= ce) && (gap <= PB'(diff));
  endfunction

  logic r_dom, r_wrs, l_dom, l_wrs;
  always_comb begin
    r_dom = dominates(r_start_q, start_q, r_err_q, cerr_q, r_wrs);
    l_dom = dominates(l_start_q, start_q, l_err_q, cerr_q, l_wrs);
  end

  logic signed [15:0] new_score;
  logic               take;
  assign new_score = ascore_q;
  assign take = !pres_q || (pscore_q < new_score) ||
                (pscore_q == new_score && pend_q > end_q) ||
                (pscore_q == new_score && pend_q == end_q && pref_q > ref_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      rd_cnt_q   <= '0;
      rd_vld_q   <= 1'b0;
      r_found_q  <= 1'b0;
      l_found_q  <= 1'b0;
      f_found_q  <= 1'b0;
      r_idx_q    <= '0;
      l_idx_q    <= '0;
      f_idx_q    <= '0;
      r_start_q  <= '0;
      l_start_q  <= '0;
      r_err_q    <= '0;
      l_err_q    <= '0;
      rej_q      <= 1'b0;
      full_q     <= 1'b0;
      r_erase_q  <= 1'b0;
      l_erase_q  <= 1'b0;
      tgt_q      <= '0;
      end_q      <= '0;
      pres_q     <= 1'b0;
      pscore_q   <= '0;
      pend_q     <= '0;
      pref_q     <= '0;
      ins_q      <= 1'b0;
      full_out_q <= 1'b0;
      inserted_o <= 1'b0;
      table_full_o <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        used_q   <= '0;
        pres_q   <= 1'b0;
        pscore_q <= '0;
        pend_q   <= '0;
        pref_q   <= '0;
        ins_q    <= 1'b0;
        full_out_q <= 1'b0;
      end
      if (cmd_i.scan_start) begin
        rd_cnt_q  <= '0;
        rd_vld_q  <= 1'b0;
        r_found_q <= 1'b0;
        l_found_q <= 1'b0;
        f_found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_vld_q <= (rd_cnt_q < CntBits'(TableDepth));
        if (rd_cnt_q < CntBits'(TableDepth)) rd_cnt_q <= rd_cnt_q + 1'b1;
        if (rd_vld_q) begin
          if (!rd_used_q) begin
            if (!f_found_q) begin
              f_found_q <= 1'b1;
              f_idx_q   <= rd_idx_q;
            end
          end else if (rd_ref_q == ref_q) begin
            if (rd_start_q >= start_q) begin
              if (!r_found_q || rd_start_q < r_start_q) begin
                r_found_q <= 1'b1;
                r_idx_q   <= rd_idx_q;
                r_start_q <= rd_start_q;
                r_err_q   <= rd_err_q;
              end
            end else if (!l_found_q || rd_start_q > l_start_q) begin
              l_found_q <= 1'b1;
              l_idx_q   <= rd_idx_q;
              l_start_q <= rd_start_q;
              l_err_q   <= rd_err_q;
            end
          end
        end
      end
      if (cmd_i.judge) begin
        rej_q     <= (r_found_q && r_dom) || (l_found_q && l_dom);
        r_erase_q <= r_found_q && r_wrs;
        l_erase_q <= l_found_q && l_wrs;
        full_q    <= !(r_found_q && r_wrs) && !(l_found_q && l_wrs) && !f_found_q;
        tgt_q     <= (r_found_q && r_wrs) ? r_idx_q :
                     (l_found_q && l_wrs) ? l_idx_q : f_idx_q;
        end_q     <= start_q + PB'(alen_q);
      end
      if (cmd_i.commit) begin
        ins_q      <= !rej_q && !full_q;
        full_out_q <= !rej_q && full_q;
        if (!rej_q && !full_q) begin
          if (r_erase_q) used_q[r_idx_q] <= 1'b0;
          if (l_erase_q) used_q[l_idx_q] <= 1'b0;
          used_q[tgt_q] <= 1'b1;
          if (take) begin
            pres_q   <= 1'b1;
            pscore_q <= new_score;
            pend_q   <= end_q;
            pref_q   <= ref_q;
          end
        end
      end
      if (cmd_i.out_load) begin
        inserted_o   <= ins_q;
        table_full_o <= full_out_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_o     <= 1'b0;
      best_score_o     <= '0;
      best_end_o       <= '0;
      best_reference_o <= '0;
    end else if (cmd_i.out_load) begin
      best_valid_o     <= pres_q;
      best_score_o     <= pscore_q;
      best_end_o       <= 32'(pend_q);
      best_reference_o <= pref_q;
    end
  end

  logic unused_rd;
  always_ff @(posedge clk_i) begin
    unused_rd <= mem_end[0][0] ^ mem_score[0][0] ^ mem_strand[0];
  end

  assign sts_o.is_clear  = op_q == OP_CLEAR;
  assign sts_o.scan_done = (rd_cnt_q == CntBits'(TableDepth)) && !rd_vld_q && !unused_rd
                           || (rd_cnt_q == CntBits'(TableDepth)) && !rd_vld_q;

endmodule

FILE: design/dfht_ctrl.sv
// Controller of the dominance filtered hit table: sequences load, scan,
// judge, write and result beats. Uses dfht_pkg.
`timescale 1ns / 1ps

module dfht_ctrl import dfht_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic   ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q;
    cmd_o   = '0;
    if (ovld_q && !out_stall_i) ovld_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_clear) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.scan_step = 1'b0;
          state_d = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        cmd_o.judge = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          ovld_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = ovld_q;

endmodule

FILE: design/dominance_filtered_hit_table.sv
// Top level of the dominance filtered hit table.
// Joins dfht_ctrl and dfht_datapath; uses dfht_pkg.
//   channel | handshake              | beat
//   in      | in_valid_i/in_stall_o  | opcode and candidate fields
//   out     | out_valid_o/out_stall_i| flags and primary hit
// An offer's result beat is loaded after a scan of the table, one slot per cycle,
// then the judge and write steps; a clear's result beat is loaded without a scan.
// The next item can be taken in the cycle after the result beat is loaded.
// Reset empties the table at once.
// A waiting result beat is held while the next item is already taken in.
`timescale 1ns / 1ps

module dominance_filtered_hit_table import dfht_pkg::*; #(
  parameter int TableDepth   = 64,
  parameter int PositionBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [9:0]         ref_index_i,
  input  logic [31:0]        span_offset_i,
  input  logic [31:0]        span_length_i,
  input  logic [31:0]        reversed_end_i,
  input  logic [7:0]         candidate_errors_i,
  input  logic [15:0]        aligned_length_i,
  input  logic [7:0]         aligned_errors_i,
  input  logic signed [15:0] aligned_score_i,
  input  logic               reverse_strand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inserted_o,
  output logic               table_full_o,
  output logic               best_valid_o,
  output logic signed [15:0] best_score_o,
  output logic [31:0]        best_end_o,
  output logic [9:0]         best_reference_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dfht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  dfht_datapath #(.TableDepth(TableDepth), .PositionBits(PositionBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .ref_index_i, .span_offset_i, .span_length_i, .reversed_end_i,
    .candidate_errors_i, .aligned_length_i, .aligned_errors_i, .aligned_score_i,
    .reverse_strand_i, .inserted_o, .table_full_o, .best_valid_o, .best_score_o,
    .best_end_o, .best_reference_o
  );

endmodule
